FILE: hdl/pds_pkg.sv
package pds_pkg;

	localparam int PIX_W      = 32;
	localparam int REF_W      = 32;
	localparam int PAR_W      = 5;
	localparam int SER_W      = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int PRE_W      = 4;
	localparam int FB_W       = 9;
	localparam int BAND_W     = 2;
	localparam int RATE_W     = 30;
	localparam int BITCLK_W   = 29;
	localparam int TGT_W      = 32;
	localparam int PROD_W     = PIX_W + PAR_W;
	localparam int DIV_NUM_W  = PROD_W - 3;
	localparam int DIV_DEN_W  = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_PAR_LANES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SER_LANES = 1'd1;

	localparam logic [PAR_W-1:0] PAR_LANES_RST = 5'd24;
	localparam logic [SER_W-1:0] SER_LANES_RST = 3'd4;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NO_BAND = 2'd1;
	localparam logic [1:0] STATUS_NO_PAIR = 2'd2;

	localparam logic [RATE_W-1:0] BAND_LIMIT [5] = '{
		30'd1000000000, 30'd500000000, 30'd250000000, 30'd125000000, 30'd62500000
	};

	typedef struct packed {
		logic [PIX_W-1:0] pixel_clock_hz;
		logic [REF_W-1:0] ref_clock_hz;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [FB_W-1:0]     feedback_div;
		logic [PRE_W-1:0]    pre_div;
		logic [BAND_W-1:0]   range_sel;
		logic [BITCLK_W-1:0] bit_clock_hz;
	} rsp_t;

	typedef struct packed {
		logic load_in;
		logic div_start;
		logic div_ref;
		logic set_target;
		logic set_band;
		logic pre_next;
		logic sweep_init;
		logic sweep_step;
		logic load_result;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic band_ok;
		logic fb_last;
		logic pre_last;
		logic best_zero;
		logic pipe_busy;
		logic out_busy;
	} sts_t;

endpackage

FILE: hdl/pds_stream_if.sv
interface pds_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/pds_div.sv
module pds_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pds_pkg::DIV_NUM_W-1:0]  dividend,
	input  logic [pds_pkg::DIV_DEN_W-1:0]  divisor,
	output logic                           busy,
	output logic [pds_pkg::DIV_NUM_W-1:0]  quotient,
	output logic [pds_pkg::DIV_DEN_W-1:0]  remainder
);

	localparam int NW = pds_pkg::DIV_NUM_W;
	localparam int VW = pds_pkg::DIV_DEN_W;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [VW:0]   shifted;
	logic          ge;

	assign shifted = {rem_q, num_q[NW-1]};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CW'(1);
			busy_q <= cnt_q != CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], ge};
			rem_q <= ge ? VW'(shifted - {1'b0, den_q}) : shifted[VW-1:0];
		end
	end

	assign busy      = busy_q;
	assign quotient  = num_q;
	assign remainder = rem_q;

endmodule

FILE: hdl/pds_dp.sv
module pds_dp #(
	parameter int PRE_DIV_STEPS = 16,
	parameter int FB_DIV_STEPS  = 512
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pds_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pds_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  pds_pkg::req_t                   req_payload,
	input  logic                            rsp_ready,
	output logic                            rsp_valid,
	output pds_pkg::rsp_t                   rsp_payload,
	input  pds_pkg::cmd_t                   cmd,
	output pds_pkg::sts_t                   sts
);

	localparam int FBW = (FB_DIV_STEPS > 1) ? $clog2(FB_DIV_STEPS) : 0;
	localparam int QW  = pds_pkg::REF_W + FBW;
	localparam int RW  = pds_pkg::RATE_W;
	localparam int VW  = pds_pkg::DIV_DEN_W;

	logic [pds_pkg::PAR_W-1:0]   par_lanes_q;
	logic [pds_pkg::SER_W-1:0]   ser_lanes_q;
	logic [pds_pkg::PROD_W-1:0]  prod_q;
	logic [pds_pkg::REF_W-1:0]   ref_q;
	logic [pds_pkg::TGT_W-1:0]   target_q;
	logic [pds_pkg::BAND_W-1:0]  band_q;
	logic                        band_ok_q;
	logic [RW-1:0]               hi_q;
	logic [RW-1:0]               lo_q;
	logic [pds_pkg::PRE_W-1:0]   pre_q;
	logic [pds_pkg::FB_W-1:0]    fb_q;
	logic [QW-1:0]               acc_q;
	logic [VW-1:0]               frac_q;

	logic                        vld_s1;
	logic                        inb_s1;
	logic [RW-1:0]               diff_s1;
	logic [RW-1:0]               rate_s1;
	logic [pds_pkg::PRE_W-1:0]   pre_s1;
	logic [pds_pkg::FB_W-1:0]    fb_s1;

	logic                        found_q;
	logic [RW-1:0]               min_err_q;
	logic [RW-1:0]               best_rate_q;
	logic [pds_pkg::PRE_W-1:0]   best_pre_q;
	logic [pds_pkg::FB_W-1:0]    best_fb_q;

	logic                        rsp_valid_q;
	pds_pkg::rsp_t               rsp_q;

	logic [pds_pkg::DIV_NUM_W-1:0] div_num;
	logic [VW-1:0]                 div_den;
	logic                          div_busy;
	logic [pds_pkg::DIV_NUM_W-1:0] div_quo;
	logic [VW-1:0]                 div_rem;

	logic [VW-1:0]               pre_den;
	logic [VW-1:0]               frac_sum;
	logic                        frac_carry;
	logic                        band_hit;
	logic [pds_pkg::BAND_W-1:0]  band_sel;
	logic [QW-1:0]               rate_full;
	logic [RW-1:0]               rate_n;
	logic [RW-1:0]               tgt_n;
	logic                        in_band;

	assign pre_den = {1'b0, pre_q} + VW'(1);
	assign div_num = cmd.div_ref ? pds_pkg::DIV_NUM_W'(ref_q)
	                             : prod_q[pds_pkg::PROD_W-1:3];
	assign div_den = cmd.div_ref ? pre_den : VW'(ser_lanes_q);

	pds_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_num),
		.divisor   (div_den),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		band_hit = 1'b0;
		band_sel = '0;
		for (int i = 0; i < 4; i++) begin
			if (target_q < pds_pkg::TGT_W'(pds_pkg::BAND_LIMIT[i]) &&
			    target_q >= pds_pkg::TGT_W'(pds_pkg::BAND_LIMIT[i+1])) begin
				band_hit = 1'b1;
				band_sel = pds_pkg::BAND_W'(i);
			end
		end
	end

	assign frac_sum   = frac_q + div_rem;
	assign frac_carry = frac_sum >= pre_den;

	assign rate_full = acc_q >> band_q;
	assign rate_n    = rate_full[RW-1:0];
	assign tgt_n     = target_q[RW-1:0];
	assign in_band   = rate_full < QW'(hi_q) && rate_full >= QW'(lo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_lanes_q <= pds_pkg::PAR_LANES_RST;
			ser_lanes_q <= pds_pkg::SER_LANES_RST;
			vld_s1      <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == pds_pkg::CFG_PAR_LANES) begin
				par_lanes_q <= cfg_data[pds_pkg::PAR_W-1:0];
			end
			if (cfg_we && cfg_index == pds_pkg::CFG_SER_LANES) begin
				ser_lanes_q <= cfg_data[pds_pkg::SER_W-1:0];
			end
			vld_s1 <= cmd.sweep_step;
			if (cmd.set_band) begin
				found_q <= 1'b0;
			end else if (vld_s1 && inb_s1 && (!found_q || diff_s1 < min_err_q)) begin
				found_q <= 1'b1;
			end
			if (cmd.load_result) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			prod_q <= req_payload.pixel_clock_hz * pds_pkg::PROD_W'(par_lanes_q);
			ref_q  <= req_payload.ref_clock_hz;
		end
		if (cmd.set_target) begin
			target_q <= (ser_lanes_q == '0) ? '0 : {div_quo[pds_pkg::TGT_W-4:0], 3'b000};
		end
		if (cmd.set_band) begin
			band_q    <= band_sel;
			band_ok_q <= band_hit;
			hi_q      <= pds_pkg::BAND_LIMIT[band_sel];
			lo_q      <= pds_pkg::BAND_LIMIT[band_sel + 3'd1];
			pre_q     <= '0;
		end else if (cmd.pre_next) begin
			pre_q <= pre_q + pds_pkg::PRE_W'(1);
		end
		if (cmd.sweep_init) begin
			acc_q  <= QW'(div_quo[pds_pkg::REF_W-1:0]);
			frac_q <= div_rem;
			fb_q   <= '0;
		end else if (cmd.sweep_step) begin
			acc_q  <= acc_q + QW'(div_quo[pds_pkg::REF_W-1:0]) + QW'(frac_carry);
			frac_q <= frac_carry ? VW'(frac_sum - pre_den) : frac_sum;
			fb_q   <= fb_q + pds_pkg::FB_W'(1);
		end
		if (cmd.sweep_step) begin
			inb_s1  <= in_band;
			diff_s1 <= (rate_n > tgt_n) ? rate_n - tgt_n : tgt_n - rate_n;
			rate_s1 <= rate_n;
			pre_s1  <= pre_q;
			fb_s1   <= fb_q;
		end
		if (vld_s1 && inb_s1 && (!found_q || diff_s1 < min_err_q)) begin
			min_err_q   <= diff_s1;
			best_rate_q <= rate_s1;
			best_pre_q  <= pre_s1;
			best_fb_q   <= fb_s1;
		end
		if (cmd.load_result) begin
			if (!band_ok_q) begin
				rsp_q.status       <= pds_pkg::STATUS_NO_BAND;
				rsp_q.feedback_div <= '0;
				rsp_q.pre_div      <= '0;
				rsp_q.range_sel    <= '0;
				rsp_q.bit_clock_hz <= '0;
			end else if (!found_q) begin
				rsp_q.status       <= pds_pkg::STATUS_NO_PAIR;
				rsp_q.feedback_div <= '0;
				rsp_q.pre_div      <= '0;
				rsp_q.range_sel    <= '0;
				rsp_q.bit_clock_hz <= '0;
			end else begin
				rsp_q.status       <= pds_pkg::STATUS_OK;
				rsp_q.feedback_div <= best_fb_q;
				rsp_q.pre_div      <= best_pre_q;
				rsp_q.range_sel    <= band_q;
				rsp_q.bit_clock_hz <= best_rate_q[RW-1:1];
			end
		end
	end

	assign sts.div_busy  = div_busy;
	assign sts.band_ok   = band_hit;
	assign sts.fb_last   = fb_q == pds_pkg::FB_W'(FB_DIV_STEPS - 1);
	assign sts.pre_last  = pre_q == pds_pkg::PRE_W'(PRE_DIV_STEPS - 1);
	assign sts.best_zero = found_q && min_err_q == '0;
	assign sts.pipe_busy = vld_s1;
	assign sts.out_busy  = rsp_valid_q && !rsp_ready;

	assign rsp_valid   = rsp_valid_q;
	assign rsp_payload = rsp_q;

endmodule

FILE: hdl/pds_ctrl.sv
module pds_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  pds_pkg::sts_t sts,
	output pds_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_TDIV_GO,
		S_TDIV_WAIT,
		S_BAND,
		S_PDIV_GO,
		S_PDIV_WAIT,
		S_SWEEP,
		S_DRAIN,
		S_RESULT
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:      cmd.load_in     = req_valid && ready_q;
			S_TDIV_GO:   cmd.div_start   = 1'b1;
			S_TDIV_WAIT: cmd.set_target  = !sts.div_busy;
			S_BAND:      cmd.set_band    = 1'b1;
			S_PDIV_GO: begin
				cmd.div_start = !sts.best_zero;
				cmd.div_ref   = 1'b1;
			end
			S_PDIV_WAIT: cmd.sweep_init  = !sts.div_busy;
			S_SWEEP: begin
				cmd.sweep_step = !sts.best_zero;
				cmd.pre_next   = !sts.best_zero && sts.fb_last && !sts.pre_last;
			end
			S_DRAIN:     cmd = '0;
			S_RESULT:    cmd.load_result = !sts.out_busy;
			default:     cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid && ready_q) begin
						ready_q <= 1'b0;
						state_q <= S_TDIV_GO;
					end
				end
				S_TDIV_GO: state_q <= S_TDIV_WAIT;
				S_TDIV_WAIT: begin
					if (!sts.div_busy) begin
						state_q <= S_BAND;
					end
				end
				S_BAND: state_q <= sts.band_ok ? S_PDIV_GO : S_RESULT;
				S_PDIV_GO: state_q <= sts.best_zero ? S_DRAIN : S_PDIV_WAIT;
				S_PDIV_WAIT: begin
					if (!sts.div_busy) begin
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (sts.best_zero) begin
						state_q <= S_DRAIN;
					end else if (sts.fb_last) begin
						state_q <= sts.pre_last ? S_DRAIN : S_PDIV_GO;
					end
				end
				S_DRAIN: begin
					if (!sts.pipe_busy) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (!sts.out_busy) begin
						ready_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_ready = ready_q;

endmodule

FILE: hdl/pll_divider_search.sv
// Channel | Direction | Payload
// req     | in        | pixel_clock_hz, ref_clock_hz
// rsp     | out       | status, feedback_div, pre_div, range_sel, bit_clock_hz
// cfg     | in        | write enable, index, data (no read-back)
//
// One item is worked on at a time. The target takes a serial division, and each pre divider
// code costs a serial division followed by a sweep over the feedback codes; an exact match
// ends the search early.
// Reset clears the controller, the result valid flag and loads the lane counts 24 and 4.
// A stalled result is held in the output register; the next item is taken once it is loaded.
module pll_divider_search #(
	parameter int PRE_DIV_STEPS = 16,
	parameter int FB_DIV_STEPS  = 512
) (
	input  logic                            clk,
	input  logic                            arst_n,
	pds_stream_if.sink                      req,
	pds_stream_if.source                    rsp,
	input  logic                            cfg_we,
	input  logic [pds_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pds_pkg::CFG_DATA_W-1:0]  cfg_data
);

	pds_pkg::cmd_t cmd;
	pds_pkg::sts_t sts;
	pds_pkg::rsp_t rsp_payload;
	logic          rsp_valid;
	logic          req_ready;

	pds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pds_dp #(
		.PRE_DIV_STEPS (PRE_DIV_STEPS),
		.FB_DIV_STEPS  (FB_DIV_STEPS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_payload (req.payload),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp_valid),
		.rsp_payload (rsp_payload),
		.cmd         (cmd),
		.sts         (sts)
	);

	assign req.ready   = req_ready;
	assign rsp.valid   = rsp_valid;
	assign rsp.payload = rsp_payload;

	// An error result carries no divider settings.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.status != pds_pkg::STATUS_OK |->
			rsp_payload.feedback_div == '0 && rsp_payload.pre_div == '0 &&
			rsp_payload.range_sel == '0 && rsp_payload.bit_clock_hz == '0)
		else $error("error result with nonzero fields");

	// Only one item is in flight.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req_ready |=> !req_ready)
		else $error("second item taken while busy");

	// A good result lies in the band that it names.
	a_in_band: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.status == pds_pkg::STATUS_OK |->
			{rsp_payload.bit_clock_hz, 1'b0} < pds_pkg::BAND_LIMIT[rsp_payload.range_sel] &&
			{rsp_payload.bit_clock_hz, 1'b1} >=
				pds_pkg::BAND_LIMIT[{1'b0, rsp_payload.range_sel} + 3'd1])
		else $error("result rate outside its band");

endmodule
